### rtl/prdec_pkg.sv
// ----------------------------------------------------------------------------
// prdec_pkg
// Types and constants shared by the raster row decoder front end, command
// queue, back end and checker.
// ----------------------------------------------------------------------------
package prdec_pkg;

  // Internal coordinate width; x and y arithmetic wraps modulo 2^COORD_BITS.
  localparam int COORD_BITS = 16;
  localparam int SPAN_BITS  = 17;   // magnitude of a 16-bit signed span
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CTRL_NOP = 8'd128;
  localparam logic [8:0] RUN_BIAS = 9'd257;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SPAN_BITS-1:0]  span_t;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_HDR = 1'b0,
    CMD_PIX = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        x_start;
    logic [15:0]        row_y;
    logic signed [15:0] row_pixels;
    logic [7:0]         data_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] x_first;
    logic [15:0] y_row;
    logic [7:0]  run_length;
    logic [7:0]  intensity;
    logic        leftward;
  } out_t;

  // One queued command: either a row header or a pixel run to place.
  typedef struct packed {
    cmd_kind_t   kind;
    coord_t      start_x;
    coord_t      line_y;
    span_t       span_abs;
    logic        reverse;
    logic [7:0]  len;
    logic [7:0]  intensity;
  } cmd_t;

endpackage

### rtl/packbits_raster_row_decoder_top.sv
// ----------------------------------------------------------------------------
// packbits_raster_row_decoder_top
// Run-length raster row decoder: headers and compressed bytes in, pixel runs
// out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of in_t beats. mode 0 opens a row (start x, y,
//           signed span), mode 1 carries one compressed byte.
//   out_* : valid/ready channel of out_t beats, one per run or literal pixel.
//   Throughput: one input beat per cycle, sustained while out_ready is high.
//   A data beat that places pixels reaches out_* through a queue entry,
//   written when the beat is accepted, and then the back end output
//   register, written when the back end pops that entry.
//   Control bytes and headers give no result beat.
//   A two-entry command queue sits between the front end (control byte
//   decode) and the back end (offset and x placement); in_ready drops only
//   when that queue is full, so a stalled receiver backs up the queue first.
//   Reset (rst_n low, synchronous) empties the queue, drops the output beat
//   and returns the decoder to a left-to-right row at x 0, y 0.
// ----------------------------------------------------------------------------
module packbits_raster_row_decoder_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  prdec_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output prdec_pkg::out_t  out_data
);
  import prdec_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  prdec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  prdec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  prdec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### rtl/prdec_front.sv
// ----------------------------------------------------------------------------
// prdec_front
// Accepts input beats, steps the control byte decoder and turns each header
// and each run or literal pixel into a command for the back end.
// ----------------------------------------------------------------------------
module prdec_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  prdec_pkg::in_t   in_data,
  input  logic             q_full,
  output logic             q_push,
  output prdec_pkg::cmd_t  q_cmd
);
  import prdec_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic       accept;
  logic       neg;
  span_t      span_abs;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign neg      = in_data.row_pixels[15];
  assign span_abs = neg ? (span_t'(17'h10000) - {1'b0, in_data.row_pixels})
                        : {1'b0, in_data.row_pixels};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CTRL;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    count_nxt       = count_r;
    q_push          = 1'b0;
    q_cmd.kind      = CMD_PIX;
    q_cmd.start_x   = coord_t'(in_data.x_start);
    q_cmd.line_y    = coord_t'(in_data.row_y);
    q_cmd.span_abs  = span_abs;
    q_cmd.reverse   = neg || (in_data.row_pixels == 16'sd0);
    q_cmd.len       = count_r;
    q_cmd.intensity = ~in_data.data_byte;
    if (accept) begin
      if (!in_data.mode) begin
        // header: drop whatever the previous row left pending
        q_push    = 1'b1;
        q_cmd.kind = CMD_HDR;
        phase_nxt = PH_CTRL;
        count_nxt = '0;
      end else begin
        case (phase_r)
          PH_RUN: begin
            q_push    = 1'b1;
            phase_nxt = PH_CTRL;
            count_nxt = '0;
          end
          PH_LIT: begin
            q_push    = 1'b1;
            q_cmd.len = 8'd1;
            count_nxt = count_r - 8'd1;
            if (count_r == 8'd1) begin
              phase_nxt = PH_CTRL;
            end
          end
          default: begin
            if (in_data.data_byte > CTRL_NOP) begin
              phase_nxt = PH_RUN;
              count_nxt = 8'(RUN_BIAS - {1'b0, in_data.data_byte});
            end else if (in_data.data_byte < CTRL_NOP) begin
              phase_nxt = PH_LIT;
              count_nxt = in_data.data_byte + 8'd1;
            end else begin
              phase_nxt = PH_CTRL;
              count_nxt = '0;
            end
          end
        endcase
      end
    end
  end

endmodule

### rtl/prdec_queue.sv
// ----------------------------------------------------------------------------
// prdec_queue
// Short command queue between front and back end; lets either side stall.
// ----------------------------------------------------------------------------
module prdec_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prdec_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output prdec_pkg::cmd_t  head_cmd
);
  import prdec_pkg::*;

  cmd_t                 slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/prdec_back.sv
// ----------------------------------------------------------------------------
// prdec_back
// Holds the row geometry and running offset, places each pixel command and
// drives the registered result beat.
// ----------------------------------------------------------------------------
module prdec_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  prdec_pkg::cmd_t  head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output prdec_pkg::out_t  out_data
);
  import prdec_pkg::*;

  coord_t               base_r;     // x of offset 0: start, or start+span-1 leftward
  coord_t               line_y_r;
  logic                 reverse_r;
  coord_t               offset_r;
  logic                 out_valid_r;
  out_t                 out_r;
  coord_t               first_x;
  logic [COORD_BITS:0]  off_sum;
  coord_t               off_next;
  logic                 is_pix;

  assign is_pix  = (head_cmd.kind == CMD_PIX);
  assign pop     = head_valid && (!is_pix || !out_valid_r || out_ready);
  assign first_x = reverse_r ? (base_r - offset_r) : (base_r + offset_r);

  // saturate the offset at the top of the coordinate range
  assign off_sum  = {1'b0, offset_r} + (COORD_BITS+1)'(head_cmd.len);
  assign off_next = off_sum[COORD_BITS] ? '1 : off_sum[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      line_y_r    <= '0;
      reverse_r   <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && !is_pix) begin
        base_r    <= head_cmd.reverse
                     ? head_cmd.start_x + coord_t'(head_cmd.span_abs) - coord_t'(1)
                     : head_cmd.start_x;
        line_y_r  <= head_cmd.line_y;
        reverse_r <= head_cmd.reverse;
        offset_r  <= '0;
      end else if (pop) begin
        offset_r  <= off_next;
      end
      if (pop && is_pix) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_pix) begin
      out_r.x_first    <= 16'(first_x);
      out_r.y_row      <= 16'(line_y_r);
      out_r.run_length <= head_cmd.len;
      out_r.intensity  <= head_cmd.intensity;
      out_r.leftward   <= reverse_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/prdec_checker.sv
// ----------------------------------------------------------------------------
// prdec_checker
// Port-level checks on the raster row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module prdec_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  prdec_pkg::in_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  prdec_pkg::out_t  out_data
);
  import prdec_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_length != 8'd0) && (out_data.run_length <= 8'd128))
    else $error("run length out of range");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind packbits_raster_row_decoder_top prdec_checker u_prdec_checker (.*);
